>>> src/assert_macros.svh
// Assertion macros used by the checker module of the escape decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/qled_pkg.sv
// Package: types, character codes and hex helpers of the escape decoder.
package qled_pkg;

  // Decoder mode, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_BODY = 6'b000010,
    MODE_ESC  = 6'b000100,
    MODE_HEXH = 6'b001000,
    MODE_HEXL = 6'b010000,
    MODE_HALT = 6'b100000
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BAD_ESC = 3'd1,
    ERR_HEX_NUL = 3'd2,
    ERR_NOT_HEX = 3'd3,
    ERR_EMPTY   = 3'd4,
    ERR_MULTI   = 3'd5
  } err_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic [1:0] COUNT_MAX = 2'd2;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] quote_char;
    logic [7:0] hex_high_char;
    logic [1:0] decoded_count;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       done_res;
    err_t       error_code;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF_HEX) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  // Digits carry their value in the low nibble; letters a-f/A-F sit at 1..6.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF_HEX) || (c >= CH_UA && c <= CH_UF)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

>>> src/qled_step.sv
// Combinational decode step: next decoder state and result for one byte.
module qled_step (
  input  logic [7:0]       char_in,
  input  logic             start_req,
  input  qled_pkg::state_t cur,
  output qled_pkg::state_t nxt,
  output qled_pkg::result_t res
);
  import qled_pkg::*;

  logic [1:0] cnt_inc;

  assign cnt_inc = (cur.decoded_count == COUNT_MAX) ? cur.decoded_count
                                                    : cur.decoded_count + 2'd1;

  always_comb begin
    nxt            = cur;
    res.byte_out   = 8'd0;
    res.byte_valid = 1'b0;
    res.done_res   = 1'b0;
    res.error_code = ERR_NONE;
    if (start_req) begin
      nxt.mode          = MODE_BODY;
      nxt.quote_char    = char_in;
      nxt.hex_high_char = 8'd0;
      nxt.decoded_count = 2'd0;
    end else begin
      unique case (cur.mode)
        MODE_BODY: begin
          if (char_in == cur.quote_char) begin
            if (cur.quote_char == CH_SQUOTE && cur.decoded_count != 2'd1) begin
              res.error_code = (cur.decoded_count == 2'd0) ? ERR_EMPTY : ERR_MULTI;
              nxt.mode       = MODE_HALT;
            end else begin
              res.done_res = 1'b1;
              nxt.mode     = MODE_IDLE;
            end
          end else if (char_in == CH_BSLASH) begin
            nxt.mode = MODE_ESC;
          end else begin
            res.byte_out      = char_in;
            res.byte_valid    = 1'b1;
            nxt.decoded_count = cnt_inc;
          end
        end
        MODE_ESC: begin
          nxt.mode          = MODE_BODY;
          res.byte_valid    = 1'b1;
          nxt.decoded_count = cnt_inc;
          case (char_in)
            CH_BSLASH: res.byte_out = CH_BSLASH;
            CH_SQUOTE: res.byte_out = CH_SQUOTE;
            CH_DQUOTE: res.byte_out = CH_DQUOTE;
            CH_N:      res.byte_out = CH_LF;
            CH_R:      res.byte_out = CH_CR;
            CH_T:      res.byte_out = CH_TAB;
            CH_ZERO:   res.byte_out = CH_NUL;
            CH_X: begin
              res.byte_valid    = 1'b0;
              nxt.decoded_count = cur.decoded_count;
              nxt.mode          = MODE_HEXH;
            end
            default: begin
              res.byte_valid    = 1'b0;
              nxt.decoded_count = cur.decoded_count;
              res.error_code    = ERR_BAD_ESC;
              nxt.mode          = MODE_HALT;
            end
          endcase
        end
        MODE_HEXH: begin
          if (char_in == CH_NUL) begin
            res.error_code = ERR_HEX_NUL;
            nxt.mode       = MODE_HALT;
          end else begin
            nxt.hex_high_char = char_in;
            nxt.mode          = MODE_HEXL;
          end
        end
        MODE_HEXL: begin
          if (char_in == CH_NUL) begin
            res.error_code = ERR_HEX_NUL;
            nxt.mode       = MODE_HALT;
          end else if (hex_ok(cur.hex_high_char) && hex_ok(char_in)) begin
            res.byte_out      = {hex_val(cur.hex_high_char), hex_val(char_in)};
            res.byte_valid    = 1'b1;
            nxt.decoded_count = cnt_inc;
            nxt.mode          = MODE_BODY;
          end else begin
            res.error_code = ERR_NOT_HEX;
            nxt.mode       = MODE_HALT;
          end
        end
        MODE_HALT: nxt.mode = MODE_HALT;
        default:   nxt.mode = MODE_IDLE;
      endcase
    end
  end

endmodule

>>> src/quoted_literal_escape_decoder.sv
// Top level: stream wrapper, decoder state and result register of the escape decoder.
//
// Usage: feed the raw bytes of a quoted literal on the slave stream, one byte
// per request, with tuser high on the opening quote byte. Every input request
// yields exactly one output request: a decoded byte (tuser bit 0), a
// completion flag for a clean closing quote (tuser bit 1) or an error code
// (tuser bits 4:2); all zero when the byte only advanced the decoder.
// An error halts decoding until the next opening quote.
// Flow: an accepted request waits in the input register and moves into the
// result register when that register is empty or being drained; its result
// is offered from the result register.
// Throughput: one byte per cycle while m_axis_tready stays high; the decode step
// is a single pass of compare-and-select logic between the input and result
// registers, and the decoder state updates in the same cycle the byte moves on.
// Reset (rst, synchronous): both stages empty, decoder idle, quote and hex
// registers cleared; bytes before the first opening quote produce empty results.
// Stall: when m_axis_tready is low the result is held; the input register
// still takes one more request, then s_axis_tready drops until the output moves.
module quoted_literal_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
  output logic [4:0]  m_axis_tuser    // [0] byte_valid, [1] done_res, [4:2] error_code
);
  import qled_pkg::*;

  // Input stage
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_start;

  // Decoder state and result stage
  state_t  dec_state;
  state_t  dec_state_next;
  result_t res_next;
  result_t out_res;
  logic    out_valid;

  logic out_open;
  logic advance;

  // The result register can take a new result when empty or being drained.
  assign out_open      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_open;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Capture payload only on an accepted request.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  qled_step u_step (
    .char_in   (in_char),
    .start_req (in_start),
    .cur       (dec_state),
    .nxt       (dec_state_next),
    .res       (res_next)
  );

  // Advance the decoder only when its byte moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state.mode          <= MODE_IDLE;
      dec_state.quote_char    <= 8'd0;
      dec_state.hex_high_char <= 8'd0;
      dec_state.decoded_count <= 2'd0;
    end else if (advance) begin
      dec_state <= dec_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.byte_out;
  assign m_axis_tuser  = {out_res.error_code, out_res.done_res, out_res.byte_valid};

endmodule

>>> src/qled_checker.sv
// Checker: port-level properties of the escape decoder, bound to the top level.
`include "assert_macros.svh"

module qled_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [4:0] m_axis_tuser
);
  import qled_pkg::*;

  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result offered right after reset")
  `ASSERT_CLK(a_err_no_byte, clk, rst, m_axis_tvalid && m_axis_tuser[4:2] != ERR_NONE |-> !m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata == 8'd0, "error result carries data or done")
  `ASSERT_CLK(a_done_no_byte, clk, rst, m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata == 8'd0, "done result carries a byte")
  `ASSERT_CLK(a_code_range, clk, rst, m_axis_tvalid |-> m_axis_tuser[4:2] <= ERR_MULTI, "error code out of range")
  `ASSERT_CLK(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind quoted_literal_escape_decoder qled_checker u_qled_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
